// ----- rtl/lgps_pkg.sv -----
package lgps_pkg;

  localparam int LEGS          = 4;
  localparam int MAX_HORIZON   = 64;
  localparam int VAL_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int HOR_W         = 7;
  localparam int STEP_W        = 6;
  // Absolute schedule time reaches 64 * 65535, which needs 22 bits.
  localparam int TACC_W        = 22;
  localparam int DIV_CNT_W     = 5;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MOD  = 5'd22;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FRAC = 5'd16;

  localparam logic [VAL_W-1:0] RST_CYCLE  = 16'd1000;
  localparam logic [VAL_W-1:0] RST_DUTY   = 16'd32768;
  localparam logic [VAL_W-1:0] RST_OFF0   = 16'd0;
  localparam logic [VAL_W-1:0] RST_OFF1   = 16'd32768;
  localparam logic [VAL_W-1:0] RST_OFF2   = 16'd32768;
  localparam logic [VAL_W-1:0] RST_OFF3   = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLE = 3'd0,
    REG_DUTY  = 3'd1,
    REG_OFF0  = 3'd2,
    REG_OFF1  = 3'd3,
    REG_OFF2  = 3'd4,
    REG_OFF3  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_ADVANCE  = 2'd0,
    CMD_RESET    = 2'd1,
    CMD_SCHEDULE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    DIV_ADV   = 2'd0,
    DIV_MOD   = 2'd1,
    DIV_FRAC  = 2'd2,
    DIV_SWING = 2'd3
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV_GO,
    ST_ADV_WAIT,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_FRAC_GO,
    ST_FRAC_WAIT,
    ST_LEG_SEL,
    ST_SWING_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    logic     div_cap;
    div_sel_t div_sel;
    logic     sw_zero;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic leg_swing;
    logic leg_last;
    logic out_free;
    logic last_step;
  } dp_stat_t;

endpackage

// ----- rtl/lgps_if.sv -----
interface lgps_in_if;
  import lgps_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [VAL_W-1:0]  time_step;
  logic [HOR_W-1:0]  horizon;
  modport source (output valid, command, time_step, horizon, input ready);
  modport sink   (input valid, command, time_step, horizon, output ready);
endinterface

interface lgps_out_if;
  import lgps_pkg::*;
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_index;
  logic [VAL_W-1:0]  phase_leg0;
  logic [VAL_W-1:0]  phase_leg1;
  logic [VAL_W-1:0]  phase_leg2;
  logic [VAL_W-1:0]  phase_leg3;
  logic [VAL_W-1:0]  swing_leg0;
  logic [VAL_W-1:0]  swing_leg1;
  logic [VAL_W-1:0]  swing_leg2;
  logic [VAL_W-1:0]  swing_leg3;
  logic [LEGS-1:0]   stance_mask;
  logic              last_result;
  modport source (output valid, step_index, phase_leg0, phase_leg1, phase_leg2, phase_leg3,
                  swing_leg0, swing_leg1, swing_leg2, swing_leg3, stance_mask, last_result,
                  input ready);
  modport sink   (input valid, step_index, phase_leg0, phase_leg1, phase_leg2, phase_leg3,
                  swing_leg0, swing_leg1, swing_leg2, swing_leg3, stance_mask, last_result,
                  output ready);
endinterface

// ----- rtl/lgps_div.sv -----
module lgps_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [lgps_pkg::VAL_W-1:0]        rem_in,
  input  logic [lgps_pkg::TACC_W-1:0]       num_in,
  input  logic [lgps_pkg::VAL_W:0]          den_in,
  input  logic [lgps_pkg::DIV_CNT_W-1:0]    nbits,
  output logic                              busy,
  output logic                              done,
  output logic [lgps_pkg::VAL_W-1:0]        rem_out,
  output logic [lgps_pkg::VAL_W-1:0]        quo_out
);
  import lgps_pkg::*;

  // Restoring divider, one quotient bit per cycle. The partial remainder
  // starts at rem_in (below the divisor) and takes the bits of num_in MSB first.
  logic [VAL_W-1:0]     rem_r;
  logic [TACC_W-1:0]    num_r;
  logic [VAL_W:0]       den_r;
  logic [VAL_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [VAL_W:0]       sh;
  logic                 ge;

  assign sh = {rem_r, num_r[TACC_W-1]};
  assign ge = (sh >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        cnt_r <= nbits;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_in;
      num_r <= num_in;
      den_r <= den_in;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? VAL_W'(sh - den_r) : VAL_W'(sh);
      num_r <= {num_r[TACC_W-2:0], 1'b0};
      quo_r <= {quo_r[VAL_W-2:0], ge};
    end
  end

  assign busy    = (cnt_r != '0);
  assign done    = done_r;
  assign rem_out = rem_r;
  assign quo_out = quo_r;

endmodule

// ----- rtl/lgps_dp.sv -----
module lgps_dp #(
  parameter int MAX_HORIZON = lgps_pkg::MAX_HORIZON
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lgps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgps_pkg::VAL_W-1:0]        cfg_wdata,
  input  logic [1:0]                        in_command,
  input  logic [lgps_pkg::VAL_W-1:0]        in_time_step,
  input  logic [lgps_pkg::HOR_W-1:0]        in_horizon,
  input  lgps_pkg::ctrl_cmd_t               cmd,
  output lgps_pkg::dp_stat_t                stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [lgps_pkg::STEP_W-1:0]       out_step_index,
  output logic [lgps_pkg::VAL_W-1:0]        out_phase [lgps_pkg::LEGS],
  output logic [lgps_pkg::VAL_W-1:0]        out_swing [lgps_pkg::LEGS],
  output logic [lgps_pkg::LEGS-1:0]         out_stance_mask,
  output logic                              out_last_result
);
  import lgps_pkg::*;

  logic [VAL_W-1:0]  cycle_r, duty_r;
  logic [VAL_W-1:0]  offset_r [LEGS];
  logic [VAL_W-1:0]  elapsed_r;
  logic [VAL_W-1:0]  dt_r;
  logic [TACC_W-1:0] t_r;
  logic [HOR_W-1:0]  hor_r;
  logic [STEP_W-1:0] j_r;
  logic [VAL_W-1:0]  tmod_r;
  logic [VAL_W-1:0]  frac_r;
  logic [1:0]        leg_r;
  logic [VAL_W-1:0]  swing_r [LEGS];
  logic              out_valid_r;

  logic [VAL_W:0]    eff_c;
  logic [VAL_W-1:0]  ph [LEGS];
  logic [LEGS-1:0]   in_swing;
  logic [HOR_W-1:0]  hor_clamp;

  logic [VAL_W-1:0]     d_rem_in;
  logic [TACC_W-1:0]    d_num_in;
  logic [VAL_W:0]       d_den_in;
  logic [DIV_CNT_W-1:0] d_nbits;
  logic                 d_busy, d_done;
  logic [VAL_W-1:0]     d_rem, d_quo;

  // A cycle length of zero behaves as one.
  assign eff_c = (cycle_r == '0) ? (VAL_W+1)'(1) : {1'b0, cycle_r};

  always_comb begin
    for (int l = 0; l < LEGS; l++) begin
      ph[l]       = offset_r[l] + frac_r;
      in_swing[l] = (ph[l] > duty_r);
    end
  end

  always_comb begin
    if (in_horizon == '0) begin
      hor_clamp = HOR_W'(1);
    end else if (32'(in_horizon) > MAX_HORIZON) begin
      hor_clamp = HOR_W'(MAX_HORIZON);
    end else begin
      hor_clamp = in_horizon;
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_ADV: begin
        d_rem_in = '0;
        d_num_in = TACC_W'({1'b0, elapsed_r} + {1'b0, dt_r});
        d_den_in = eff_c;
        d_nbits  = DIV_STEPS_MOD;
      end
      DIV_MOD: begin
        d_rem_in = '0;
        d_num_in = t_r;
        d_den_in = eff_c;
        d_nbits  = DIV_STEPS_MOD;
      end
      DIV_FRAC: begin
        d_rem_in = tmod_r;
        d_num_in = '0;
        d_den_in = eff_c;
        d_nbits  = DIV_STEPS_FRAC;
      end
      default: begin
        d_rem_in = ph[leg_r] - duty_r;
        d_num_in = '0;
        d_den_in = (VAL_W+1)'(1 << VAL_W) - {1'b0, duty_r};
        d_nbits  = DIV_STEPS_FRAC;
      end
    endcase
  end

  lgps_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .rem_in  (d_rem_in),
    .num_in  (d_num_in),
    .den_in  (d_den_in),
    .nbits   (d_nbits),
    .busy    (d_busy),
    .done    (d_done),
    .rem_out (d_rem),
    .quo_out (d_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_r     <= RST_CYCLE;
      duty_r      <= RST_DUTY;
      offset_r[0] <= RST_OFF0;
      offset_r[1] <= RST_OFF1;
      offset_r[2] <= RST_OFF2;
      offset_r[3] <= RST_OFF3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CYCLE: cycle_r     <= cfg_wdata;
        REG_DUTY:  duty_r      <= cfg_wdata;
        REG_OFF0:  offset_r[0] <= cfg_wdata;
        REG_OFF1:  offset_r[1] <= cfg_wdata;
        REG_OFF2:  offset_r[2] <= cfg_wdata;
        REG_OFF3:  offset_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && in_command == CMD_RESET) begin
        elapsed_r <= '0;
      end else if (cmd.div_cap && cmd.div_sel == DIV_ADV) begin
        elapsed_r <= d_rem;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dt_r  <= in_time_step;
      j_r   <= '0;
      hor_r <= (in_command == CMD_SCHEDULE) ? hor_clamp : HOR_W'(1);
      t_r   <= (in_command == CMD_RESET) ? '0 : TACC_W'(elapsed_r);
    end else if (cmd.emit) begin
      j_r <= j_r + STEP_W'(1);
      t_r <= t_r + TACC_W'(dt_r);
    end else if (cmd.div_cap && cmd.div_sel == DIV_ADV) begin
      t_r <= TACC_W'(d_rem);
    end
    if (cmd.div_cap && cmd.div_sel == DIV_MOD) begin
      tmod_r <= d_rem;
    end
    if (cmd.div_cap && cmd.div_sel == DIV_FRAC) begin
      frac_r <= d_quo;
      leg_r  <= '0;
    end else if (cmd.div_cap && cmd.div_sel == DIV_SWING) begin
      swing_r[leg_r] <= d_quo;
      leg_r          <= leg_r + 2'd1;
    end else if (cmd.sw_zero) begin
      swing_r[leg_r] <= '0;
      leg_r          <= leg_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_step_index  <= j_r;
      out_stance_mask <= ~in_swing;
      out_last_result <= ({1'b0, j_r} + HOR_W'(1) == hor_r);
      for (int l = 0; l < LEGS; l++) begin
        out_phase[l] <= ph[l];
        out_swing[l] <= swing_r[l];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign stat.div_busy   = d_busy;
  assign stat.div_done   = d_done;
  assign stat.leg_swing  = in_swing[leg_r];
  assign stat.leg_last   = (leg_r == 2'(LEGS - 1));
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.last_step  = ({1'b0, j_r} + HOR_W'(1) == hor_r);

endmodule

// ----- rtl/lgps_ctrl.sv -----
module lgps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_command,
  output logic                 in_ready,
  input  lgps_pkg::dp_stat_t   stat,
  output lgps_pkg::ctrl_cmd_t  cmd
);
  import lgps_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.div_sel   = DIV_MOD;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          unique case (in_command)
            CMD_ADVANCE:  state_nxt = ST_ADV_GO;
            CMD_RESET:    state_nxt = ST_MOD_GO;
            CMD_SCHEDULE: state_nxt = ST_MOD_GO;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADV_GO: begin
        cmd.div_sel   = DIV_ADV;
        cmd.div_start = 1'b1;
        state_nxt     = ST_ADV_WAIT;
      end
      ST_ADV_WAIT: begin
        cmd.div_sel = DIV_ADV;
        cmd.div_cap = stat.div_done;
        if (stat.div_done) begin
          state_nxt = ST_MOD_GO;
        end
      end
      ST_MOD_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        cmd.div_cap = stat.div_done;
        if (stat.div_done) begin
          state_nxt = ST_FRAC_GO;
        end
      end
      ST_FRAC_GO: begin
        cmd.div_sel   = DIV_FRAC;
        cmd.div_start = 1'b1;
        state_nxt     = ST_FRAC_WAIT;
      end
      ST_FRAC_WAIT: begin
        cmd.div_sel = DIV_FRAC;
        cmd.div_cap = stat.div_done;
        if (stat.div_done) begin
          state_nxt = ST_LEG_SEL;
        end
      end
      ST_LEG_SEL: begin
        cmd.div_sel = DIV_SWING;
        // A leg in stance needs no division: its swing value is zero.
        if (stat.leg_swing) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_SWING_WAIT;
        end else begin
          cmd.sw_zero = 1'b1;
          state_nxt   = stat.leg_last ? ST_EMIT : ST_LEG_SEL;
        end
      end
      ST_SWING_WAIT: begin
        cmd.div_sel = DIV_SWING;
        cmd.div_cap = stat.div_done;
        if (stat.div_done) begin
          state_nxt = stat.leg_last ? ST_EMIT : ST_LEG_SEL;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.last_step ? ST_IDLE : ST_MOD_GO;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/legged_gait_phase_scheduler.sv -----
// Gait phase scheduler for a four-legged walker.
// Input channel in_if carries command, time_step and horizon. Advance adds
// time_step to the elapsed time modulo the cycle length, reset time clears it;
// each gives one result. Schedule gives horizon results (clamped to 1..64)
// for elapsed + j * time_step without changing the elapsed time. Code 3 is
// taken and dropped. Output channel out_if carries per-leg phase and swing in
// Q0.16, the stance mask, step_index and last_result on the final result.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 cycle
// length, 1 duty factor, 2..5 leg offsets). The user writes only while the
// block is idle; the block itself does not enforce this.
// All divisions share one restoring divider, one bit per cycle. A result
// divides for time modulo cycle, phase fraction and each swing leg (a stance
// leg skips it), then registers; advance first wraps the elapsed time.
// in_if.ready is high only between items; the next item is taken while the
// last result still waits in the output register. When the receiver stalls,
// the next result is held back until the output register is free.
// Reset restores the register defaults and clears the elapsed time.
module legged_gait_phase_scheduler #(
  parameter int MAX_HORIZON = lgps_pkg::MAX_HORIZON
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lgps_in_if.sink                        in_if,
  lgps_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [lgps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgps_pkg::VAL_W-1:0]     cfg_wdata
);
  import lgps_pkg::*;

  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  logic [VAL_W-1:0] phase [LEGS];
  logic [VAL_W-1:0] swing [LEGS];

  lgps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_if.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lgps_dp #(.MAX_HORIZON(MAX_HORIZON)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_if.command),
    .in_time_step    (in_if.time_step),
    .in_horizon      (in_if.horizon),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_step_index  (out_if.step_index),
    .out_phase       (phase),
    .out_swing       (swing),
    .out_stance_mask (out_if.stance_mask),
    .out_last_result (out_if.last_result)
  );

  assign out_if.phase_leg0 = phase[0];
  assign out_if.phase_leg1 = phase[1];
  assign out_if.phase_leg2 = phase[2];
  assign out_if.phase_leg3 = phase[3];
  assign out_if.swing_leg0 = swing[0];
  assign out_if.swing_leg1 = swing[1];
  assign out_if.swing_leg2 = swing[2];
  assign out_if.swing_leg3 = swing[3];

`ifndef SYNTHESIS
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && in_if.command != CMD_NONE |=> !in_if.ready)
    else $error("scheduler ready right after taking an item");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_if.valid)
    else $error("result not presented after emit");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_if.ready)
    else $error("result emitted while idle");
`endif

endmodule
